/* src/rtp_video_nal_fragmenter_macros.svh */
// ----------------------------------------------------------------------------
// RTP video NAL fragmenter assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RTP_VIDEO_NAL_FRAGMENTER_MACROS_SVH
`define RTP_VIDEO_NAL_FRAGMENTER_MACROS_SVH

// same-cycle implication
`define RVNF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RVNF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rvnf_pkg.sv */
// ----------------------------------------------------------------------------
// RTP video NAL fragmenter package
// Shared types, codes and the constant divider used by the timestamp path.
// ----------------------------------------------------------------------------
package rvnf_pkg;

  localparam logic [15:0] HEADER_BYTES = 16'd12;
  localparam logic [15:0] MTU_MIN      = 16'd64;
  localparam logic [15:0] MTU_RESET    = 16'd1200;
  localparam logic [6:0]  PT264_RESET  = 7'd96;
  localparam logic [6:0]  PT265_RESET  = 7'd97;

  // FU-A indicator type (H.264) and FU payload header type (H.265)
  localparam logic [7:0] FUA_TYPE     = 8'd28;
  localparam logic [5:0] FU_TYPE_H265 = 6'd49;
  localparam logic [7:0] MASK_NRI     = 8'he0;
  localparam logic [7:0] MASK_H265_FB = 8'h81;
  localparam logic [7:0] FU_START     = 8'h80;
  localparam logic [7:0] FU_END       = 8'h40;

  // 90 kHz over 1 MHz = 9/100 = (9/4)/25
  localparam logic [3:0]  TS_NUM      = 4'd9;
  localparam logic [21:0] DIV25_M     = 22'd2684355;
  localparam int          DIV25_SHIFT = 26;
  localparam logic [4:0]  DIV25_D     = 5'd25;

  localparam logic [2:0] REG_MTU   = 3'd0;
  localparam logic [2:0] REG_SSRC  = 3'd1;
  localparam logic [2:0] REG_PT264 = 3'd2;
  localparam logic [2:0] REG_PT265 = 3'd3;
  localparam logic [2:0] REG_SEQ   = 3'd4;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PULL    = 1'b1;
  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  typedef enum logic [1:0] {
    ST_PACKET    = 2'd0,
    ST_BAD_START = 2'd1,
    ST_IDLE      = 2'd2
  } status_e;

  typedef struct packed {
    logic        op;
    logic        codec;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    logic [31:0] length;
    logic [47:0] pts;
    logic        eof;
    logic [6:0]  pt_override;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        marker;
    logic [15:0] seq;
    logic [6:0]  pt;
    logic [1:0]  prefix_len;
    logic [7:0]  pb0;
    logic [7:0]  pb1;
    logic [7:0]  pb2;
    logic [31:0] offset;
    logic [15:0] length;
    logic        last;
    logic        new_ts;
  } desc_t;

  typedef struct packed {
    logic [16:0] q;
    logic [4:0]  r;
  } div25_t;

  // exact for v < 2**21
  function automatic div25_t div25(input logic [20:0] v);
    logic [42:0] prod;
    logic [21:0] back;
    logic [20:0] diff;
    div25_t      res;
    prod  = {22'd0, v} * {21'd0, DIV25_M};
    res.q = prod[42:DIV25_SHIFT];
    back  = {5'd0, res.q} * {17'd0, DIV25_D};
    diff  = v - back[20:0];
    res.r = diff[4:0];
    return res;
  endfunction

endpackage

/* src/rvnf_ts_pipe.sv */
// ----------------------------------------------------------------------------
// RVNF timestamp pipeline
// pts_us * 9 / 100 in three stages: scale, then base-2^16 long division by 25.
// ----------------------------------------------------------------------------
module rvnf_ts_pipe (
  input  logic        clk_i,
  input  logic [2:0]  load_i,
  input  logic [47:0] pts_i,
  output logic [31:0] ts_o
);

  logic [48:0] y_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic [4:0]  r2_q, r1_q;
  logic [15:0] y1_q, y0a_q, y0b_q, q1_q;
  logic [50:0] x9;
  rvnf_pkg::div25_t d2, d3, d4;

  always_comb begin
    x9 = {4'd0, pts_i[46:0]} + {1'b0, pts_i[46:0], 3'd0};
    d2 = rvnf_pkg::div25({4'd0, y_q[48:32]});
    d3 = rvnf_pkg::div25({r2_q, y1_q});
    d4 = rvnf_pkg::div25({r1_q, y0b_q});
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      y_q    <= x9[50:2];
      neg1_q <= pts_i[47];
    end
    if (load_i[1]) begin
      r2_q   <= d2.r;
      y1_q   <= y_q[31:16];
      y0a_q  <= y_q[15:0];
      neg2_q <= neg1_q;
    end
    if (load_i[2]) begin
      q1_q   <= d3.q[15:0];
      r1_q   <= d3.r;
      y0b_q  <= y0a_q;
      neg3_q <= neg2_q;
    end
  end

  assign ts_o = neg3_q ? 32'd0 : {q1_q, d4.q[15:0]};

endmodule

/* src/rtp_video_nal_fragmenter.sv */
// ----------------------------------------------------------------------------
// RTP video NAL fragmenter
// Turns H.264/H.265 NAL descriptors into RTP packet descriptors (FU-A / FU).
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): op 0 starts a NAL and yields its
// first packet descriptor, op 1 requests the next descriptor of that NAL.
// Every request yields exactly one result on out_valid_o/out_ready_i.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i. The
// user must make writes while no request is in flight; the block does not
// enforce this. The accept edge loads the input register, then three
// timestamp stages and the output register follow. Throughput: one request
// per cycle while the receiver keeps up; the timestamp path is three stages,
// a scale by 9/4 and then a base-2^16 divide by 25.
// Each stage moves on when the next one is empty or moving, so a stalled
// receiver only backs up the pipeline; bubbles still take new requests.
// Reset empties the pipeline, drops any pending NAL, loads the register
// defaults and sets the sequence counter to zero.
// ----------------------------------------------------------------------------
module rtp_video_nal_fragmenter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic               codec_i,
  input  logic [7:0]         nal_header_first_i,
  input  logic [7:0]         nal_header_second_i,
  input  logic [31:0]        nal_length_i,
  input  logic signed [47:0] pts_us_i,
  input  logic               end_of_frame_i,
  input  logic [6:0]         pt_override_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               marker_bit_o,
  output logic [15:0]        sequence_number_o,
  output logic [31:0]        rtp_timestamp_o,
  output logic [6:0]         rtp_pt_o,
  output logic [1:0]         prefix_length_o,
  output logic [7:0]         prefix_byte0_o,
  output logic [7:0]         prefix_byte1_o,
  output logic [7:0]         prefix_byte2_o,
  output logic [31:0]        payload_offset_o,
  output logic [15:0]        payload_length_o,
  output logic               last_of_nal_o
);

  // config
  logic [15:0] mtu_q;
  logic        ssrc_nz_q;
  logic [6:0]  pt264_q, pt265_q;

  // NAL state
  logic        pending_q;
  logic        held_codec_q;
  logic [31:0] held_len_q;
  logic [31:0] next_off_q;
  logic [7:0]  held_h1_q, held_h2_q;
  logic        held_eof_q;
  logic [6:0]  held_pt_q;
  logic [15:0] seq_q;
  logic [15:0] cmax_q;
  logic [31:0] held_ts_q;

  // pipeline
  rvnf_pkg::item_t a_q;
  rvnf_pkg::desc_t s1_q, s2_q, s3_q, s4_q, desc_d, frag;
  logic            a_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic            take1, take2, take3, take4, fire_a;
  logic [31:0]     ts_calc, ts_sel, s4_ts_q;

  // start decode
  logic        is_start;
  logic [6:0]  pt_sel;
  logic        bad_basic, fits, bad_frag;
  logic [1:0]  first_new;
  logic [15:0] ovh;

  // fragment
  logic        f_codec, f_eof, f_last, f_start_bit;
  logic [31:0] f_len, f_off, remain;
  logic [15:0] f_cmax, chunk;
  logic [7:0]  f_h1, f_h2, fu;
  logic [6:0]  f_pt;
  logic [1:0]  f_first;

  assign take4      = !s4_v_q || out_ready_i;
  assign take3      = !s3_v_q || take4;
  assign take2      = !s2_v_q || take3;
  assign take1      = !s1_v_q || take2;
  assign in_ready_o = !a_v_q || take1;
  assign fire_a     = a_v_q && take1;

  always_comb begin
    is_start  = (a_q.op == rvnf_pkg::OP_START);
    pt_sel    = (a_q.pt_override != 7'd0) ? a_q.pt_override :
                (a_q.codec == rvnf_pkg::CODEC_H265) ? pt265_q : pt264_q;
    bad_basic = !ssrc_nz_q || (a_q.length == 32'd0) || (pt_sel == 7'd0);
    fits      = a_q.length <= {16'd0, mtu_q - rvnf_pkg::HEADER_BYTES};
    first_new = (a_q.codec == rvnf_pkg::CODEC_H265) ? 2'd2 : 2'd1;
    ovh       = rvnf_pkg::HEADER_BYTES +
                ((a_q.codec == rvnf_pkg::CODEC_H265) ? 16'd3 : 16'd2);
    bad_frag  = (mtu_q <= ovh) || (a_q.length <= {30'd0, first_new});

    f_codec = is_start ? a_q.codec : held_codec_q;
    f_len   = is_start ? a_q.length : held_len_q;
    f_off   = is_start ? {30'd0, first_new} : next_off_q;
    f_cmax  = is_start ? (mtu_q - ovh) : cmax_q;
    f_h1    = is_start ? a_q.hdr_first : held_h1_q;
    f_h2    = is_start ? a_q.hdr_second : held_h2_q;
    f_eof   = is_start ? a_q.eof : held_eof_q;
    f_pt    = is_start ? pt_sel : held_pt_q;
    f_first = (f_codec == rvnf_pkg::CODEC_H265) ? 2'd2 : 2'd1;

    remain      = f_len - f_off;
    f_last      = remain <= {16'd0, f_cmax};
    chunk       = f_last ? remain[15:0] : f_cmax;
    f_start_bit = (f_off == {30'd0, f_first});

    fu = (f_codec == rvnf_pkg::CODEC_H265) ? {2'd0, f_h1[6:1]} : {3'd0, f_h1[4:0]};
    if (f_start_bit) fu = fu | rvnf_pkg::FU_START;
    if (f_last)      fu = fu | rvnf_pkg::FU_END;

    frag            = '0;
    frag.status     = rvnf_pkg::ST_PACKET;
    frag.marker     = f_eof && f_last;
    frag.seq        = seq_q;
    frag.pt         = f_pt;
    frag.offset     = f_off;
    frag.length     = chunk;
    frag.last       = f_last;
    frag.new_ts     = is_start;
    if (f_codec == rvnf_pkg::CODEC_H265) begin
      frag.prefix_len = 2'd3;
      frag.pb0        = (f_h1 & rvnf_pkg::MASK_H265_FB) | {1'b0, rvnf_pkg::FU_TYPE_H265, 1'b0};
      frag.pb1        = f_h2;
      frag.pb2        = fu;
    end else begin
      frag.prefix_len = 2'd2;
      frag.pb0        = (f_h1 & rvnf_pkg::MASK_NRI) | rvnf_pkg::FUA_TYPE;
      frag.pb1        = fu;
      frag.pb2        = 8'd0;
    end

    desc_d = '0;
    if (!is_start) begin
      if (pending_q) desc_d = frag;
      else           desc_d.status = rvnf_pkg::ST_IDLE;
    end else if (bad_basic) begin
      desc_d.status = rvnf_pkg::ST_BAD_START;
    end else if (fits) begin
      desc_d.status = rvnf_pkg::ST_PACKET;
      desc_d.marker = a_q.eof;
      desc_d.seq    = seq_q;
      desc_d.pt     = pt_sel;
      desc_d.length = a_q.length[15:0];
      desc_d.last   = 1'b1;
      desc_d.new_ts = 1'b1;
    end else if (bad_frag) begin
      desc_d.status = rvnf_pkg::ST_BAD_START;
    end else begin
      desc_d = frag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q        <= rvnf_pkg::MTU_RESET;
      ssrc_nz_q    <= 1'b0;
      pt264_q      <= rvnf_pkg::PT264_RESET;
      pt265_q      <= rvnf_pkg::PT265_RESET;
      pending_q    <= 1'b0;
      held_codec_q <= 1'b0;
      held_len_q   <= '0;
      next_off_q   <= '0;
      held_h1_q    <= '0;
      held_h2_q    <= '0;
      held_eof_q   <= 1'b0;
      held_pt_q    <= '0;
      seq_q        <= '0;
      cmax_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rvnf_pkg::REG_MTU:
            mtu_q <= (cfg_data_i[15:0] < rvnf_pkg::MTU_MIN) ? rvnf_pkg::MTU_MIN :
                     cfg_data_i[15:0];
          rvnf_pkg::REG_SSRC:  ssrc_nz_q <= (cfg_data_i != 32'd0);
          rvnf_pkg::REG_PT264: pt264_q   <= cfg_data_i[6:0];
          rvnf_pkg::REG_PT265: pt265_q   <= cfg_data_i[6:0];
          rvnf_pkg::REG_SEQ:   seq_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (fire_a) begin
        if (desc_d.status == rvnf_pkg::ST_PACKET) seq_q <= seq_q + 16'd1;
        if (is_start) begin
          pending_q <= 1'b0;
          if (!bad_basic) begin
            held_codec_q <= a_q.codec;
            held_len_q   <= a_q.length;
            held_h1_q    <= a_q.hdr_first;
            held_h2_q    <= a_q.hdr_second;
            held_eof_q   <= a_q.eof;
            held_pt_q    <= pt_sel;
            if (!fits && !bad_frag) begin
              cmax_q     <= f_cmax;
              next_off_q <= f_off + {16'd0, f_cmax};
              pending_q  <= !f_last;
            end
          end
        end else if (pending_q) begin
          next_off_q <= f_off + {16'd0, f_cmax};
          pending_q  <= !f_last;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      held_ts_q <= '0;
    end else begin
      if (in_ready_o) a_v_q <= in_valid_i;
      if (take1) s1_v_q <= a_v_q;
      if (take2) s2_v_q <= s1_v_q;
      if (take3) s3_v_q <= s2_v_q;
      if (take4) s4_v_q <= s3_v_q;
      if (s3_v_q && take4 && s3_q.new_ts) held_ts_q <= ts_calc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      a_q.op          <= op_i;
      a_q.codec       <= codec_i;
      a_q.hdr_first   <= nal_header_first_i;
      a_q.hdr_second  <= nal_header_second_i;
      a_q.length      <= nal_length_i;
      a_q.pts         <= pts_us_i;
      a_q.eof         <= end_of_frame_i;
      a_q.pt_override <= pt_override_i;
    end
    if (take1) s1_q <= desc_d;
    if (take2) s2_q <= s1_q;
    if (take3) s3_q <= s2_q;
    if (take4) begin
      s4_q    <= s3_q;
      s4_ts_q <= ts_sel;
    end
  end

  rvnf_ts_pipe u_ts_pipe (
    .clk_i  (clk_i),
    .load_i ({take3, take2, take1}),
    .pts_i  (a_q.pts),
    .ts_o   (ts_calc)
  );

  assign ts_sel = (s3_q.status != rvnf_pkg::ST_PACKET) ? 32'd0 :
                  s3_q.new_ts ? ts_calc : held_ts_q;

  assign out_valid_o       = s4_v_q;
  assign status_o          = s4_q.status;
  assign marker_bit_o      = s4_q.marker;
  assign sequence_number_o = s4_q.seq;
  assign rtp_timestamp_o   = s4_ts_q;
  assign rtp_pt_o          = s4_q.pt;
  assign prefix_length_o   = s4_q.prefix_len;
  assign prefix_byte0_o    = s4_q.pb0;
  assign prefix_byte1_o    = s4_q.pb1;
  assign prefix_byte2_o    = s4_q.pb2;
  assign payload_offset_o  = s4_q.offset;
  assign payload_length_o  = s4_q.length;
  assign last_of_nal_o     = s4_q.last;

endmodule

/* src/rvnf_port_checker.sv */
// ----------------------------------------------------------------------------
// RVNF port checker
// Port-level checks on the result channel of the NAL fragmenter.
// ----------------------------------------------------------------------------
`include "rtp_video_nal_fragmenter_macros.svh"

module rvnf_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        marker_bit_o,
  input logic [15:0] sequence_number_o,
  input logic [31:0] rtp_timestamp_o,
  input logic [15:0] payload_length_o,
  input logic [1:0]  prefix_length_o,
  input logic [7:0]  prefix_byte0_o,
  input logic [7:0]  prefix_byte2_o,
  input logic        last_of_nal_o
);

  `RVNF_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sequence_number_o) && $stable(status_o), "result changed while stalled")
  `RVNF_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != rvnf_pkg::ST_PACKET), !marker_bit_o && sequence_number_o == 16'd0 && rtp_timestamp_o == 32'd0 && payload_length_o == 16'd0 && prefix_length_o == 2'd0, "non-packet result has nonzero fields")
  `RVNF_ASSERT_NOW(a_single_last, out_valid_o && (status_o == rvnf_pkg::ST_PACKET) && (prefix_length_o == 2'd0), last_of_nal_o, "single packet not marked last")
  `RVNF_ASSERT_NOW(a_fua_prefix, out_valid_o && (status_o == rvnf_pkg::ST_PACKET) && (prefix_length_o == 2'd2), prefix_byte0_o[4:0] == rvnf_pkg::FUA_TYPE[4:0] && prefix_byte2_o == 8'd0, "bad FU-A prefix")
  `RVNF_ASSERT_NOW(a_marker_last, out_valid_o && marker_bit_o, last_of_nal_o, "marker set before last fragment")

endmodule

bind rtp_video_nal_fragmenter rvnf_port_checker u_rvnf_port_checker (.*);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// RTP video NAL fragmenter testbench
// Sends NAL start and packet requests with randomized gaps on both channels
// and compares every result against an in-bench packetizer model or, for
// some directed requests, a fixed expected result. Register settings are
// changed between phases while no request is in flight.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rvnf_pkg::*;

  localparam longint unsigned TICKS_PER_S = 90000;
  localparam longint unsigned US_PER_S    = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    status_e     status;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [6:0]  pt;
    logic [1:0]  prefix_len;
    logic [7:0]  pb0;
    logic [7:0]  pb1;
    logic [7:0]  pb2;
    logic [31:0] offset;
    logic [15:0] len;
    logic        last;
  } packet_t;

  typedef struct {
    bit          write;
    logic [2:0]  idx;
    logic [31:0] data;
    item_t       req;
    bit          typed;
    packet_t     want;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               op_i;
  logic               codec_i;
  logic [7:0]         nal_header_first_i;
  logic [7:0]         nal_header_second_i;
  logic [31:0]        nal_length_i;
  logic signed [47:0] pts_us_i;
  logic               end_of_frame_i;
  logic [6:0]         pt_override_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic               marker_bit_o;
  logic [15:0]        sequence_number_o;
  logic [31:0]        rtp_timestamp_o;
  logic [6:0]         rtp_pt_o;
  logic [1:0]         prefix_length_o;
  logic [7:0]         prefix_byte0_o;
  logic [7:0]         prefix_byte1_o;
  logic [7:0]         prefix_byte2_o;
  logic [31:0]        payload_offset_o;
  logic [15:0]        payload_length_o;
  logic               last_of_nal_o;

  rtp_video_nal_fragmenter u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .codec_i             (codec_i),
    .nal_header_first_i  (nal_header_first_i),
    .nal_header_second_i (nal_header_second_i),
    .nal_length_i        (nal_length_i),
    .pts_us_i            (pts_us_i),
    .end_of_frame_i      (end_of_frame_i),
    .pt_override_i       (pt_override_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .marker_bit_o        (marker_bit_o),
    .sequence_number_o   (sequence_number_o),
    .rtp_timestamp_o     (rtp_timestamp_o),
    .rtp_pt_o            (rtp_pt_o),
    .prefix_length_o     (prefix_length_o),
    .prefix_byte0_o      (prefix_byte0_o),
    .prefix_byte1_o      (prefix_byte1_o),
    .prefix_byte2_o      (prefix_byte2_o),
    .payload_offset_o    (payload_offset_o),
    .payload_length_o    (payload_length_o),
    .last_of_nal_o       (last_of_nal_o)
  );

  // packetizer model: registers and held NAL
  logic [15:0] mtu_q;
  logic [31:0] ssrc_q;
  logic [6:0]  pt264_q;
  logic [6:0]  pt265_q;
  logic        nal_open;
  logic        nal_codec;
  logic        nal_eof;
  logic [31:0] nal_len;
  logic [31:0] nal_next;
  logic [31:0] nal_ts;
  logic [7:0]  nal_hdr0;
  logic [7:0]  nal_hdr1;
  logic [6:0]  nal_pt;
  logic [15:0] seq_ctr;
  logic [31:0] chunk_max;

  packet_t   pending_packets[$];
  plan_row_t plan[$];
  int        tx_idle_pct;
  int        rx_stall_pct;
  int        idle_cycles;
  int        n_fail, n_checked, n_frag, n_rejected, n_no_nal;
  int        n_start, n_pull, n_writes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_stall_pct);

  function automatic logic [31:0] rtp_ticks(logic [47:0] pts);
    longint unsigned us, secs, frac;
    us = {16'd0, pts};
    if (pts[47] || us == 0) return '0;
    secs = us / US_PER_S;
    frac = us % US_PER_S;
    return 32'(secs * TICKS_PER_S + frac * TICKS_PER_S / US_PER_S);
  endfunction

  function automatic packet_t next_fragment();
    logic [31:0]     first;
    longint unsigned remain, chunk;
    bit              last;
    logic [7:0]      fu;
    packet_t         p;
    first  = (nal_codec == CODEC_H265) ? 32'd2 : 32'd1;
    remain = 64'(nal_len) - 64'(nal_next);
    chunk  = (remain < 64'(chunk_max)) ? remain : 64'(chunk_max);
    last   = (64'(nal_next) + chunk >= 64'(nal_len));
    p        = '0;
    p.status = ST_PACKET;
    p.marker = nal_eof && last;
    p.seq    = seq_ctr;
    p.ts     = nal_ts;
    p.pt     = nal_pt;
    seq_ctr  = seq_ctr + 16'd1;
    if (nal_codec == CODEC_H265) begin
      fu           = {2'b00, nal_hdr0[6:1]};
      p.prefix_len = 2'd3;
      p.pb0        = (nal_hdr0 & MASK_H265_FB) | {1'b0, FU_TYPE_H265, 1'b0};
      p.pb1        = nal_hdr1;
    end else begin
      fu           = {3'b000, nal_hdr0[4:0]};
      p.prefix_len = 2'd2;
      p.pb0        = (nal_hdr0 & MASK_NRI) | FUA_TYPE;
    end
    if (nal_next == first) fu = fu | FU_START;
    if (last) fu = fu | FU_END;
    if (nal_codec == CODEC_H265) p.pb2 = fu;
    else p.pb1 = fu;
    p.offset = nal_next;
    p.len    = 16'(chunk);
    p.last   = last;
    nal_next = nal_next + 32'(chunk);
    if (last) nal_open = 1'b0;
    return p;
  endfunction

  function automatic packet_t packetize(item_t r);
    logic [6:0]      pt;
    longint unsigned overhead;
    packet_t         p;
    p = '0;
    if (r.op == OP_PULL) begin
      if (!nal_open) begin
        p.status = ST_IDLE;
        return p;
      end
      return next_fragment();
    end
    pt = (r.pt_override != 0) ? r.pt_override :
         (r.codec == CODEC_H265) ? pt265_q : pt264_q;
    nal_open = 1'b0;
    p.status = ST_BAD_START;
    if (ssrc_q == 0 || r.length == 0 || pt == 0) return p;
    nal_codec = r.codec;
    nal_len   = r.length;
    nal_hdr0  = r.hdr_first;
    nal_hdr1  = r.hdr_second;
    nal_eof   = r.eof;
    nal_ts    = rtp_ticks(r.pts);
    nal_pt    = pt;
    if (64'(r.length) + 64'(HEADER_BYTES) <= 64'(mtu_q)) begin
      p.status = ST_PACKET;
      p.marker = r.eof;
      p.seq    = seq_ctr;
      p.ts     = nal_ts;
      p.pt     = pt;
      p.len    = r.length[15:0];
      p.last   = 1'b1;
      seq_ctr  = seq_ctr + 16'd1;
      return p;
    end
    overhead = 64'(HEADER_BYTES) + ((r.codec == CODEC_H265) ? 64'd3 : 64'd2);
    if (64'(mtu_q) <= overhead || r.length <= ((r.codec == CODEC_H265) ? 2 : 1))
      return p;
    chunk_max = 32'(mtu_q) - 32'(overhead);
    nal_next  = (r.codec == CODEC_H265) ? 32'd2 : 32'd1;
    nal_open  = 1'b1;
    return next_fragment();
  endfunction

  function automatic packet_t status_only(status_e s);
    packet_t p;
    p        = '0;
    p.status = s;
    return p;
  endfunction

  function automatic plan_row_t req(logic op, logic codec, logic [7:0] h0, logic [7:0] h1,
                                    logic [31:0] len, logic [47:0] pts, logic eof,
                                    logic [6:0] ovr);
    plan_row_t s;
    s.write = 1'b0;
    s.idx   = '0;
    s.data  = '0;
    s.req   = '{op: op, codec: codec, hdr_first: h0, hdr_second: h1, length: len,
                pts: pts, eof: eof, pt_override: ovr};
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic plan_row_t expecting(plan_row_t s, packet_t p);
    s.typed = 1'b1;
    s.want  = p;
    return s;
  endfunction

  function automatic plan_row_t wr(logic [2:0] idx, logic [31:0] data);
    plan_row_t s;
    s       = req(OP_PULL, CODEC_H264, '0, '0, '0, '0, 1'b0, '0);
    s.write = 1'b1;
    s.idx   = idx;
    s.data  = data;
    return s;
  endfunction

  function automatic item_t random_item();
    item_t r;
    r.codec       = 1'($urandom_range(1));
    r.hdr_first   = 8'($urandom);
    r.hdr_second  = 8'($urandom);
    r.pts         = $urandom_range(1) ? {16'($urandom), $urandom}
                                      : 48'($urandom_range(32'h7fff_ffff));
    r.eof         = 1'($urandom_range(1));
    r.pt_override = ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom);
    if (nal_open) r.op = ($urandom_range(19) == 0) ? OP_START : OP_PULL;
    else r.op = ($urandom_range(9) == 0) ? OP_PULL : OP_START;
    case ($urandom_range(9))
      0, 1, 2, 3: r.length = $urandom_range(32'(mtu_q) - 32'(HEADER_BYTES), 1);
      4, 5, 6, 7: r.length = $urandom_range(32'(mtu_q) * 4, 32'(mtu_q) - 11);
      8:          r.length = $urandom_range(3);
      default:    r.length = $urandom;
    endcase
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MTU:   mtu_q = (data[15:0] < MTU_MIN) ? MTU_MIN : data[15:0];
      REG_SSRC:  ssrc_q = data;
      REG_PT264: pt264_q = data[6:0];
      REG_PT265: pt265_q = data[6:0];
      REG_SEQ:   seq_ctr = data[15:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic issue(item_t r, bit typed, packet_t want);
    packet_t got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    op_i                <= r.op;
    codec_i             <= r.codec;
    nal_header_first_i  <= r.hdr_first;
    nal_header_second_i <= r.hdr_second;
    nal_length_i        <= r.length;
    pts_us_i            <= r.pts;
    end_of_frame_i      <= r.eof;
    pt_override_i       <= r.pt_override;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = packetize(r);
    pending_packets.push_back(typed ? want : got);
    if (r.op == OP_PULL) n_pull++;
    else n_start++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    packet_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_packets.size() == 0) begin
        $display("%0t: unexpected packet, expected none, got status %0d seq %0h",
                 $time, status_o, sequence_number_o);
        n_fail++;
      end else begin
        want = pending_packets.pop_front();
        n_checked++;
        if (want.prefix_len != 0) n_frag++;
        if (want.status == ST_BAD_START) n_rejected++;
        if (want.status == ST_IDLE) n_no_nal++;
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("marker", 32'(want.marker), 32'(marker_bit_o));
        check_field("sequence", 32'(want.seq), 32'(sequence_number_o));
        check_field("timestamp", want.ts, rtp_timestamp_o);
        check_field("rtp_pt", 32'(want.pt), 32'(rtp_pt_o));
        check_field("prefix_length", 32'(want.prefix_len), 32'(prefix_length_o));
        check_field("prefix_byte0", 32'(want.pb0), 32'(prefix_byte0_o));
        check_field("prefix_byte1", 32'(want.pb1), 32'(prefix_byte1_o));
        check_field("prefix_byte2", 32'(want.pb2), 32'(prefix_byte2_o));
        check_field("payload_offset", want.offset, payload_offset_o);
        check_field("payload_length", 32'(want.len), 32'(payload_length_o));
        check_field("last_of_nal", 32'(want.last), 32'(last_of_nal_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or packet moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] mtu_w;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    in_valid_i          <= 1'b0;
    op_i                <= OP_START;
    codec_i             <= CODEC_H264;
    nal_header_first_i  <= '0;
    nal_header_second_i <= '0;
    nal_length_i        <= '0;
    pts_us_i            <= '0;
    end_of_frame_i      <= 1'b0;
    pt_override_i       <= '0;
    n_fail       = 0;
    n_checked    = 0;
    n_frag       = 0;
    n_rejected   = 0;
    n_no_nal     = 0;
    n_start      = 0;
    n_pull       = 0;
    n_writes     = 0;
    tx_idle_pct  = 6;
    rx_stall_pct = 76;
    mtu_q     = MTU_RESET;
    ssrc_q    = '0;
    pt264_q   = PT264_RESET;
    pt265_q   = PT265_RESET;
    seq_ctr   = '0;
    nal_open  = 1'b0;
    nal_codec = CODEC_H264;
    nal_eof   = 1'b0;
    nal_len   = '0;
    nal_next  = '0;
    nal_ts    = '0;
    nal_hdr0  = '0;
    nal_hdr1  = '0;
    nal_pt    = '0;
    chunk_max = '0;

    // directed: out of reset, then errors, fits, fragments, wraps, extremes
    plan.push_back(expecting(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0,
                                 7'd0), status_only(ST_IDLE)));
    plan.push_back(expecting(req(OP_START, CODEC_H264, 8'h65, 8'h00, 32'd100, 48'd1000,
                                 1'b1, 7'd0), status_only(ST_BAD_START)));
    plan.push_back(wr(REG_SSRC, 32'hffff_ffff));
    plan.push_back(wr(REG_SEQ, 32'h0000_fffe));
    plan.push_back(expecting(req(OP_START, CODEC_H264, 8'h65, 8'h00, 32'd100,
                                 48'd1000000, 1'b1, 7'd0),
                             '{status: ST_PACKET, marker: 1'b1, seq: 16'hfffe,
                               ts: 32'd90000, pt: PT264_RESET, prefix_len: 2'd0,
                               pb0: 8'h00, pb1: 8'h00, pb2: 8'h00, offset: 32'd0,
                               len: 16'd100, last: 1'b1}));
    plan.push_back(expecting(req(OP_START, CODEC_H264, 8'h65, 8'h00, 32'd0, 48'd5, 1'b1,
                                 7'd0), status_only(ST_BAD_START)));
    plan.push_back(req(OP_START, CODEC_H264, 8'h00, 8'h00, 32'd1188, 48'd0, 1'b0, 7'd0));
    plan.push_back(req(OP_START, CODEC_H264, 8'hff, 8'hff, 32'd1189,
                       48'h7fff_ffff_ffff, 1'b1, 7'd127));
    plan.push_back(req(OP_PULL, CODEC_H265, 8'hff, 8'hff, 32'hffff_ffff,
                       48'hffff_ffff_ffff, 1'b1, 7'd127));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    plan.push_back(req(OP_START, CODEC_H265, 8'hff, 8'haa, 32'd3000,
                       48'hffff_ffff_ffff, 1'b0, 7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    // new start abandons the H.265 NAL mid way
    plan.push_back(req(OP_START, CODEC_H264, 8'h7c, 8'h55, 32'd5000, 48'd1, 1'b1, 7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    plan.push_back(wr(REG_MTU, 32'd0));
    plan.push_back(req(OP_START, CODEC_H265, 8'h01, 8'h00, 32'd200, 48'd12345678, 1'b1,
                       7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    // MTU change mid NAL: fragment size stays as latched
    plan.push_back(wr(REG_MTU, 32'h0000_ffff));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));
    plan.push_back(wr(REG_PT264, 32'd0));
    plan.push_back(expecting(req(OP_START, CODEC_H264, 8'h41, 8'h00, 32'd10, 48'd9, 1'b0,
                                 7'd0), status_only(ST_BAD_START)));
    plan.push_back(req(OP_START, CODEC_H264, 8'h41, 8'h00, 32'd10, 48'd9, 1'b0, 7'd1));
    plan.push_back(wr(REG_PT265, 32'd127));
    plan.push_back(req(OP_START, CODEC_H265, 8'h26, 8'h01, 32'd65523, 48'd999999, 1'b1,
                       7'd0));
    plan.push_back(req(OP_START, CODEC_H265, 8'h80, 8'hff, 32'hffff_ffff,
                       48'h8000_0000_0000, 1'b1, 7'd0));
    plan.push_back(req(OP_PULL, CODEC_H264, 8'h00, 8'h00, 32'd0, 48'd0, 1'b0, 7'd0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].write) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        issue(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      tx_idle_pct  = (ph < 4) ? 6 : (ph < 8) ? 76 : 0;
      rx_stall_pct = (ph < 4) ? 76 : (ph < 8) ? 6 : 0;
      case (ph % 4)
        0:       mtu_w = $urandom_range(63);
        1:       mtu_w = $urandom_range(300, 64);
        2:       mtu_w = $urandom_range(2000, 300);
        default: mtu_w = $urandom;
      endcase
      if (ph == PHASES - 1) mtu_w = 32'h0000_ffff;
      write_reg(REG_MTU, mtu_w);
      write_reg(REG_SSRC, (ph == 5) ? 32'd0 : $urandom);
      write_reg(REG_PT264, ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(127));
      write_reg(REG_PT265, ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(127));
      write_reg(REG_SEQ, $urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) == 0) drain();
        issue(random_item(), 1'b0, '0);
      end
    end

    drain();
    $display("Sent %0d NAL starts and %0d packet requests over %0d register writes;",
             n_start, n_pull, n_writes);
    $display("checked %0d packets: %0d fragments, %0d rejected starts, %0d with no NAL.",
             n_checked, n_frag, n_rejected, n_no_nal);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
